@@ src/tcce_pkg.sv @@
// Shared types and constants of the text cell console engine.
// Used by every module of the block; depends on nothing else.
package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 12;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;

  localparam int CFG_IW = 1;
  localparam int CFG_DW = 8;

  localparam logic [CFG_IW-1:0] CFG_TEXT_ATTRIBUTE  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_CONSOLE_ENABLED = CFG_IW'(1);

  localparam logic [ATTR_W-1:0] ATTR_RESET = ATTR_W'(8'h07);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_SCROLL = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_WRITE  = 3'd1,
    OP_READ   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SCROLL = 3'd4
  } op_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  char_code;
    logic               end_of_string;
    logic [IDX_W-1:0]   cell_index;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_pos;
    logic              cursor_update;
    logic [CELL_W-1:0] cell_data;
  } result_t;

  // One unit of memory work for the back end, with its finished cursor report.
  typedef struct packed {
    op_t                op;
    logic               write_after;
    logic [CELL_AW-1:0] addr;
    logic [CELL_W-1:0]  data;
    logic [CELL_W-1:0]  blank;
    result_t            res;
  } cmd_t;

endpackage

@@ src/tcce_front.sv @@
// Front end: configuration registers, cursor tracking and item classification.
// Turns each accepted item into one back-end command; depends on tcce_pkg.
module tcce_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  tcce_pkg::item_t              item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcce_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DW-1:0]  cfg_data,
  output logic                         cmd_push,
  output tcce_pkg::cmd_t               cmd
);
  import tcce_pkg::*;

  localparam logic [COL_W:0] TAB_STEP = (COL_W+1)'(8);
  localparam logic [COL_W:0] TAB_MASK = ~(COL_W+1)'(7);

  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;
  logic [ATTR_W-1:0] text_attribute;
  logic              console_enabled;

  logic [COL_W-1:0] column_next;
  logic [ROW_W-1:0] row_next;
  logic [COL_W:0]   tab_col;
  logic [COL_W-1:0] wr_col;
  logic [ROW_W-1:0] wr_row;
  logic [CELL_W-1:0] blank;

  function automatic logic [ROW_W-1:0] advance_row(input logic [ROW_W-1:0] r);
    return (r < ROW_W'(ROWS)) ? r + ROW_W'(1) : r;
  endfunction

  function automatic logic [POS_W-1:0] linear_pos(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return POS_W'(r) * POS_W'(COLUMNS) + POS_W'(c);
  endfunction

  assign cfg_ready = 1'b1;
  assign cmd_push  = accept;
  assign blank     = {text_attribute, CH_SPACE};

  always_comb begin
    column_next = column;
    row_next    = row;
    tab_col     = ({1'b0, column} + TAB_STEP) & TAB_MASK;
    wr_col      = column;
    wr_row      = row;
    cmd         = '0;
    cmd.op      = OP_NOP;
    cmd.blank   = blank;
    if (console_enabled) begin
      case (item.kind)
        KIND_CHAR: begin
          cmd.res.cursor_update = item.end_of_string;
          case (item.char_code)
            CH_NUL: begin
            end
            CH_LF: begin
              column_next = '0;
              row_next    = advance_row(row);
            end
            CH_CR: begin
              column_next = '0;
            end
            CH_TAB: begin
              if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                column_next = '0;
                row_next    = advance_row(row);
              end else begin
                column_next = tab_col[COL_W-1:0];
              end
            end
            CH_BS: begin
              if (column != '0) begin
                column_next = column - COL_W'(1);
                // Past the bottom row there is no cell to blank.
                if (row < ROW_W'(ROWS)) begin
                  cmd.op   = OP_WRITE;
                  cmd.addr = CELL_AW'(linear_pos(row, column_next));
                  cmd.data = blank;
                end
              end
            end
            default: begin
              if (column >= COL_W'(COLUMNS)) begin
                wr_col = '0;
                wr_row = advance_row(row);
              end
              if (wr_row >= ROW_W'(ROWS)) begin
                cmd.op          = OP_SCROLL;
                cmd.write_after = 1'b1;
                wr_row          = ROW_W'(ROWS - 1);
              end else begin
                cmd.op = OP_WRITE;
              end
              cmd.addr    = CELL_AW'(linear_pos(wr_row, wr_col));
              cmd.data    = {text_attribute, item.char_code};
              column_next = wr_col + COL_W'(1);
              row_next    = wr_row;
            end
          endcase
        end
        KIND_CLEAR: begin
          cmd.op                = OP_CLEAR;
          cmd.res.cursor_update = 1'b1;
          column_next           = '0;
          row_next              = '0;
        end
        KIND_SCROLL: begin
          cmd.op = OP_SCROLL;
          if (row != '0) begin
            row_next = row - ROW_W'(1);
          end
        end
        KIND_READ: begin
          if (POS_W'(item.cell_index) < POS_W'(CELL_COUNT)) begin
            cmd.op   = OP_READ;
            cmd.addr = CELL_AW'(item.cell_index);
          end
        end
        default: begin
        end
      endcase
    end
    cmd.res.cursor_column = column_next;
    cmd.res.cursor_row    = row_next;
    cmd.res.cursor_pos    = linear_pos(row_next, column_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      row             <= '0;
      text_attribute  <= ATTR_RESET;
      console_enabled <= 1'b1;
    end else begin
      if (accept) begin
        column <= column_next;
        row    <= row_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEXT_ATTRIBUTE:  text_attribute  <= cfg_data[ATTR_W-1:0];
          CFG_CONSOLE_ENABLED: console_enabled <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ src/tcce_cmd_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on tcce_pkg for the command type.
module tcce_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcce_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output tcce_pkg::cmd_t  head
);
  import tcce_pkg::*;

  cmd_t       slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
    end
  end

endmodule

@@ src/tcce_back.sv @@
// Back end: screen memory, the sequencer that carries out commands, and the
// two-entry result queue. Depends on tcce_pkg.
module tcce_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  tcce_pkg::cmd_t   cmd,
  output logic             cmd_pop,
  output logic             init_busy,
  output logic             empty,
  input  logic             pop,
  output tcce_pkg::result_t result
);
  import tcce_pkg::*;

  localparam logic [CELL_AW-1:0] CELL_LAST  = CELL_AW'(CELL_COUNT - 1);
  localparam logic [CELL_AW-1:0] TAIL_START = CELL_AW'((ROWS - 1) * COLUMNS);
  localparam logic [CELL_AW-1:0] ROW_STEP   = CELL_AW'(COLUMNS);

  typedef enum logic [7:0] {
    ST_INIT     = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_READ     = 8'b0000_0100,
    ST_FILL     = 8'b0000_1000,
    ST_MOVE     = 8'b0001_0000,
    ST_MOVE_END = 8'b0010_0000,
    ST_BLANK    = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CELL_AW-1:0] ptr;
  logic [CELL_AW-1:0] ptr_next;
  logic               mv_valid;
  logic [CELL_AW-1:0] mv_addr;

  logic [CELL_W-1:0]  screen_cells [CELL_COUNT];
  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [CELL_AW-1:0] mem_raddr;
  logic [CELL_W-1:0]  rd_data;

  result_t    res_slots [2];
  logic       res_rd_ptr;
  logic       res_wr_ptr;
  logic [1:0] res_count;
  logic       res_room;
  logic       res_push;
  result_t    res_data;

  assign init_busy = (state == ST_INIT);
  assign res_room  = (res_count != 2'd2);
  assign empty     = (res_count == 2'd0);
  assign result    = res_slots[res_rd_ptr];

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    mem_we     = 1'b0;
    mem_waddr  = ptr;
    mem_wdata  = cmd.blank;
    mem_re     = 1'b0;
    mem_raddr  = cmd.addr;
    res_push   = 1'b0;
    res_data   = cmd.res;
    cmd_pop    = 1'b0;
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        ptr_next  = ptr + CELL_AW'(1);
        if (ptr == CELL_LAST) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Only the command started here fills the result queue, so room checked at the
        // start of a command still holds when its result is pushed.
        if (cmd_valid && res_room) begin
          case (cmd.op)
            OP_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = cmd.addr;
              mem_wdata = cmd.data;
              res_push  = 1'b1;
              cmd_pop   = 1'b1;
            end
            OP_READ: begin
              mem_re     = 1'b1;
              state_next = ST_READ;
            end
            OP_CLEAR: begin
              ptr_next   = '0;
              state_next = ST_FILL;
            end
            OP_SCROLL: begin
              ptr_next   = ROW_STEP;
              state_next = ST_MOVE;
            end
            default: begin
              res_push = 1'b1;
              cmd_pop  = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_data.cell_data = rd_data;
        res_push           = 1'b1;
        cmd_pop            = 1'b1;
        state_next         = ST_IDLE;
      end
      ST_FILL: begin
        mem_we   = 1'b1;
        ptr_next = ptr + CELL_AW'(1);
        if (ptr == CELL_LAST) begin
          res_push   = 1'b1;
          cmd_pop    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MOVE: begin
        // Read one row below and write back the cell read in the previous cycle.
        mem_re    = 1'b1;
        mem_raddr = ptr;
        mem_we    = mv_valid;
        mem_waddr = mv_addr;
        mem_wdata = rd_data;
        ptr_next  = ptr + CELL_AW'(1);
        if (ptr == CELL_LAST) begin
          state_next = ST_MOVE_END;
        end
      end
      ST_MOVE_END: begin
        mem_we     = 1'b1;
        mem_waddr  = mv_addr;
        mem_wdata  = rd_data;
        ptr_next   = TAIL_START;
        state_next = ST_BLANK;
      end
      ST_BLANK: begin
        mem_we   = 1'b1;
        ptr_next = ptr + CELL_AW'(1);
        if (ptr == CELL_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        mem_we     = cmd.write_after;
        mem_waddr  = cmd.addr;
        mem_wdata  = cmd.data;
        res_push   = 1'b1;
        cmd_pop    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_cells[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= screen_cells[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    mv_addr <= ptr - ROW_STEP;
    if (rst) begin
      state    <= ST_INIT;
      ptr      <= '0;
      mv_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      mv_valid <= (state == ST_MOVE);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_slots[res_wr_ptr] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_rd_ptr <= 1'b0;
      res_wr_ptr <= 1'b0;
      res_count  <= '0;
    end else begin
      if (res_push) begin
        res_wr_ptr <= ~res_wr_ptr;
      end
      if (pop && !empty) begin
        res_rd_ptr <= ~res_rd_ptr;
      end
      res_count <= res_count + 2'(res_push ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

@@ src/text_cell_console_engine_unit.sv @@
// Text cell console engine, 80x25 cells of attribute and character.
// Items come in on a queue-style push/full port, results leave on an
// empty/pop port, and two registers are written through the cfg port.
// Every accepted item gives exactly one result beat carrying the cursor.
// A character write, control code or ignored item is carried out in the
// back end's idle state, so its result passes through the command queue and
// the result queue registers; such items sustain one per cycle while the back
// end is idle and the receiver keeps popping. A cell read also waits for the
// registered memory read. Clear writes all 2000 cells one per cycle; a
// scroll, or a character that scrolls the screen, copies 1920 cells and
// blanks 80 with one read and one write a cycle on the screen memory. The
// front end keeps taking items into a two-entry command queue while the back
// end works, then holds full.
// After reset, full stays high while the screen memory is swept to zero;
// configuration writes are taken at any time (cfg_ready is always high)
// but belong in idle periods. When the receiver stops popping, the two-entry
// result queue fills, the back end stops starting commands, and full rises
// once the command queue is also full. No beat is lost.
module text_cell_console_engine_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  tcce_pkg::item_t              item,
  output logic                         empty,
  input  logic                         pop,
  output tcce_pkg::result_t            result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcce_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DW-1:0]  cfg_data
);
  import tcce_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd_head;
  logic init_busy;

  assign full   = cmd_full || init_busy;
  assign accept = push && !full;

  tcce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  tcce_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .valid     (cmd_valid),
    .head      (cmd_head)
  );

  tcce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .init_busy (init_busy),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // No item may enter while the screen memory is still being swept.
  assert property (@(posedge clk) disable iff (rst) init_busy |-> !accept)
    else $error("item accepted during the reset sweep");

  // The back end only retires a command that is present.
  assert property (@(posedge clk) disable iff (rst) cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  // A command is never pushed into a full queue.
  assert property (@(posedge clk) disable iff (rst) cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

  // The sweep runs only right after reset.
  assert property (@(posedge clk) disable iff (rst) !init_busy |=> !init_busy)
    else $error("reset sweep restarted without reset");

endmodule
